[rtl/core/assert_macros.svh]
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock and active-low reset
`define ASSERT_CLKED(label, clk_sig, rstn_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
        else $error("assertion failed");

// Same, using clk and rst_n from the enclosing scope
`define ASSERT_DEFAULT(label, prop) \
    `ASSERT_CLKED(label, clk, rst_n, prop)

`endif

[rtl/core/kett_pkg.sv]
// Types and constants for the keyed event throttle table
package kett_pkg;

    localparam int KEY_IN_W   = 16;
    localparam int LEVEL_W    = 3;
    localparam int TIME_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 3;

    localparam logic [STATUS_W-1:0] STATUS_PASS      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_LOW_LEVEL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_THROTTLED = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } kett_state_t;

    typedef struct packed {
        logic match;
        logic in_window;
    } cmp_res_t;

endpackage

[rtl/core/kett_mem.sv]
// Slot memory: one write port, one read port, registered read data
module kett_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 48,
    parameter int AW    = 3
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/kett_cmp.sv]
// Slot compare: key match and throttle window check for one entry
module kett_cmp #(
    parameter int KW = 16
) (
    input  logic                     entry_valid,
    input  logic [KW-1:0]            entry_key,
    input  logic [31:0]              entry_time,
    input  logic [KW-1:0]            key,
    input  logic [31:0]              now,
    input  logic [31:0]              interval,
    output kett_pkg::cmp_res_t       res
);

    import kett_pkg::*;

    logic [TIME_W-1:0] elapsed;

    // elapsed time wraps modulo 2^32
    assign elapsed       = now - entry_time;
    assign res.match     = entry_valid && (entry_key == key);
    assign res.in_window = elapsed < interval;

endmodule

[rtl/core/keyed_event_throttle_table_unit.sv]
// Per-key event rate limiter: top level with scan controller and result register
// Each accepted request yields one result. A request below min_level goes straight from
// accept to result. Otherwise the slot memory is read one entry per cycle from
// slot 0 until the key matches or all SLOTS entries are seen; the result state then
// decides and, for a passed request, writes back; only then can the next request be taken.
// The slot memory has a single read port, so entries are read one at a time. The
// result waits in an output register, so a stalled result blocks the block only once
// the next result is ready. Valid bits clear at reset; no clearing pass is needed.
module keyed_event_throttle_table_unit #(
    parameter int SLOTS    = 8,
    parameter int KEY_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [2:0]                         cfg_wr_data,
    input  logic                               evt_valid,
    output logic                               evt_stall,
    input  logic [kett_pkg::KEY_IN_W-1:0]      key_id,
    input  logic [kett_pkg::LEVEL_W-1:0]       level,
    input  logic [kett_pkg::TIME_W-1:0]        min_interval,
    input  logic [kett_pkg::TIME_W-1:0]        now_ms,
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic [kett_pkg::STATUS_W-1:0]      status,
    output logic [kett_pkg::SLOT_OUT_W-1:0]    slot_index,
    output logic                               evicted
);

    import kett_pkg::*;

    localparam int KW   = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
    localparam int AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MEMW = KW + TIME_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

    kett_state_t state_reg, state_next;

    logic [AW-1:0]       scan_addr_reg, scan_addr_next;
    logic                low_reg, low_next;
    logic                hit_reg, hit_next;
    logic                win_reg, win_next;
    logic [AW-1:0]       hit_slot_reg, hit_slot_next;
    logic                free_found_reg, free_found_next;
    logic [AW-1:0]       free_slot_reg, free_slot_next;
    logic [SLOTS-1:0]    valid_reg;
    logic [LEVEL_W-1:0]  min_level_reg;

    logic [KW-1:0]       key_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   interval_reg;

    logic                res_valid_reg, res_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SLOT_OUT_W-1:0] slot_reg, slot_next;
    logic                evicted_reg, evicted_next;

    logic                evt_accept;
    logic                out_free;
    logic                res_load;
    logic                scan_last;
    logic [AW-1:0]       rd_addr;
    logic                mem_we;
    logic [AW-1:0]       pass_slot;
    logic [MEMW-1:0]     rd_data;
    cmp_res_t            cmp_res;

    assign evt_stall  = (state_reg != ST_IDLE);
    assign evt_accept = evt_valid && !evt_stall;
    assign out_free   = !res_valid_reg || !res_stall;
    assign scan_last  = (scan_addr_reg == LAST_SLOT);

    // read one slot ahead so the data for scan_addr_reg is ready in each scan cycle
    assign rd_addr = (state_reg == ST_SCAN && !scan_last) ? scan_addr_reg + AW'(1) : '0;

    assign pass_slot = hit_reg ? hit_slot_reg : (free_found_reg ? free_slot_reg : '0);

    kett_mem #(
        .DEPTH (SLOTS),
        .WIDTH (MEMW),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (pass_slot),
        .wdata ({key_reg, now_reg}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    kett_cmp #(
        .KW (KW)
    ) u_cmp (
        .entry_valid (valid_reg[scan_addr_reg]),
        .entry_key   (rd_data[MEMW-1:TIME_W]),
        .entry_time  (rd_data[TIME_W-1:0]),
        .key         (key_reg),
        .now         (now_reg),
        .interval    (interval_reg),
        .res         (cmp_res)
    );

    always_comb
    begin
        state_next      = state_reg;
        scan_addr_next  = scan_addr_reg;
        low_next        = low_reg;
        hit_next        = hit_reg;
        win_next        = win_reg;
        hit_slot_next   = hit_slot_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        res_load        = 1'b0;
        mem_we          = 1'b0;
        status_next     = STATUS_PASS;
        slot_next       = SLOT_OUT_W'(pass_slot);
        evicted_next    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (evt_accept)
                begin
                    scan_addr_next  = '0;
                    hit_next        = 1'b0;
                    win_next        = 1'b0;
                    free_found_next = 1'b0;
                    low_next        = (level < min_level_reg);
                    state_next      = (level < min_level_reg) ? ST_RESULT : ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (cmp_res.match)
                begin
                    hit_next      = 1'b1;
                    hit_slot_next = scan_addr_reg;
                    win_next      = cmp_res.in_window;
                    state_next    = ST_RESULT;
                end
                else
                begin
                    // note the lowest free slot on the way
                    if (!valid_reg[scan_addr_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_slot_next  = scan_addr_reg;
                    end
                    if (scan_last)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        scan_addr_next = scan_addr_reg + AW'(1);
                    end
                end
            end

            ST_RESULT:
            begin
                if (low_reg)
                begin
                    status_next = STATUS_LOW_LEVEL;
                    slot_next   = '0;
                end
                else if (hit_reg && win_reg)
                begin
                    status_next = STATUS_THROTTLED;
                end
                else
                begin
                    evicted_next = !hit_reg && !free_found_reg;
                end

                if (out_free)
                begin
                    res_load   = 1'b1;
                    mem_we     = !low_reg && !(hit_reg && win_reg);
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_addr_reg  <= '0;
            low_reg        <= 1'b0;
            hit_reg        <= 1'b0;
            win_reg        <= 1'b0;
            hit_slot_reg   <= '0;
            free_found_reg <= 1'b0;
            free_slot_reg  <= '0;
            valid_reg      <= '0;
            min_level_reg  <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_addr_reg  <= scan_addr_next;
            low_reg        <= low_next;
            hit_reg        <= hit_next;
            win_reg        <= win_next;
            hit_slot_reg   <= hit_slot_next;
            free_found_reg <= free_found_next;
            free_slot_reg  <= free_slot_next;
            res_valid_reg  <= res_valid_next;
            if (mem_we)
            begin
                valid_reg[pass_slot] <= 1'b1;
            end
            if (cfg_wr_en)
            begin
                min_level_reg <= cfg_wr_data;
            end
        end
    end

    // request payload, held for the whole scan
    always_ff @(posedge clk)
    begin
        if (evt_accept)
        begin
            key_reg      <= key_id[KW-1:0];
            now_reg      <= now_ms;
            interval_reg <= min_interval;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            status_reg  <= status_next;
            slot_reg    <= slot_next;
            evicted_reg <= evicted_next;
        end
    end

    assign res_valid  = res_valid_reg;
    assign status     = status_reg;
    assign slot_index = slot_reg;
    assign evicted    = evicted_reg;

endmodule

[rtl/core/kett_checker.sv]
// Port-level checker for the keyed event throttle table, bound to the top level
`include "assert_macros.svh"

module kett_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               evt_valid,
    input  logic                               evt_stall,
    input  logic                               res_valid,
    input  logic                               res_stall,
    input  logic [kett_pkg::STATUS_W-1:0]      status,
    input  logic [kett_pkg::SLOT_OUT_W-1:0]    slot_index,
    input  logic                               evicted
);

    import kett_pkg::*;

    // a stalled result holds
    `ASSERT_DEFAULT(a_res_hold, res_valid && res_stall |=> res_valid && $stable({status, slot_index, evicted}))

    // one request at a time: busy right after an accept
    `ASSERT_DEFAULT(a_busy_after_accept, evt_valid && !evt_stall |=> evt_stall)

    // a level drop reports slot 0 and never evicts
    `ASSERT_DEFAULT(a_low_level_fields, res_valid && status == STATUS_LOW_LEVEL |-> slot_index == '0 && !evicted)

    // only a passed request can evict
    `ASSERT_DEFAULT(a_evict_only_pass, res_valid && evicted |-> status == STATUS_PASS)

endmodule

bind keyed_event_throttle_table_unit kett_checker u_kett_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .evt_valid  (evt_valid),
    .evt_stall  (evt_stall),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .status     (status),
    .slot_index (slot_index),
    .evicted    (evicted)
);

[tb/tb_top.sv]
// Testbench for keyed_event_throttle_table_unit: directed and random requests, self-checking
module tb_top;
    import kett_pkg::*;

    localparam int SLOTS         = 8;
    localparam int KEY_BITS      = 16;
    localparam int SETTLE_CYCLES = SLOTS + 8;
    localparam int POOL_MAX      = 16;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  evicted;
    } throttle_res_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [2:0]            cfg_wr_data;
    logic                  evt_valid;
    logic                  evt_stall;
    logic [KEY_IN_W-1:0]   key_id;
    logic [LEVEL_W-1:0]    level;
    logic [TIME_W-1:0]     min_interval;
    logic [TIME_W-1:0]     now_ms;
    logic                  res_valid;
    logic                  res_stall;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic                  evicted;

    // predictor state
    logic                tbl_valid [SLOTS];
    logic [KEY_BITS-1:0] tbl_key   [SLOTS];
    logic [TIME_W-1:0]   tbl_stamp [SLOTS];
    logic [2:0]          level_floor;

    throttle_res_t pending_results [$];
    int            fail_cnt = 0;

    // receiver idling controls
    int  stall_pct    = 0;
    bit  hold_off_req = 1'b0;
    int  hold_off_len = 0;

    // random traffic state
    logic [KEY_IN_W-1:0] key_pool [POOL_MAX];
    int                  pool_n;
    logic [TIME_W-1:0]   clk_ms;

    keyed_event_throttle_table_unit #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .evt_valid    (evt_valid),
        .evt_stall    (evt_stall),
        .key_id       (key_id),
        .level        (level),
        .min_interval (min_interval),
        .now_ms       (now_ms),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .status       (status),
        .slot_index   (slot_index),
        .evicted      (evicted)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic throttle_res_t throttle_predict(input logic [KEY_IN_W-1:0] key,
                                                       input logic [LEVEL_W-1:0]  lvl,
                                                       input logic [TIME_W-1:0]   intv,
                                                       input logic [TIME_W-1:0]   now);
        throttle_res_t       r;
        logic [KEY_BITS-1:0] k;
        logic [TIME_W-1:0]   elapsed;
        int                  hit;
        int                  slot;
        logic                evict;
        r     = '0;
        k     = key[KEY_BITS-1:0];
        hit   = -1;
        slot  = -1;
        evict = 1'b0;
        if (lvl < level_floor)
        begin
            r.status = STATUS_LOW_LEVEL;
            return r;
        end
        for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && tbl_valid[i] && tbl_key[i] == k)
                hit = i;
        if (hit >= 0)
        begin
            slot    = hit;
            elapsed = now - tbl_stamp[hit];
            if (elapsed < intv)
            begin
                r.status = STATUS_THROTTLED;
                r.slot   = slot[SLOT_OUT_W-1:0];
                return r;
            end
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
                if (slot < 0 && !tbl_valid[i])
                    slot = i;
            if (slot < 0)
            begin
                slot  = 0;
                evict = 1'b1;
            end
        end
        tbl_valid[slot] = 1'b1;
        tbl_key[slot]   = k;
        tbl_stamp[slot] = now;
        r.status  = STATUS_PASS;
        r.slot    = slot[SLOT_OUT_W-1:0];
        r.evicted = evict;
        return r;
    endfunction

    // Called at a rising edge; leaves valid high so a following request needs no re-raise.
    task automatic send_event(input logic [KEY_IN_W-1:0] key, input logic [LEVEL_W-1:0] lvl,
                              input logic [TIME_W-1:0] intv, input logic [TIME_W-1:0] now);
        evt_valid    <= 1'b1;
        key_id       <= key;
        level        <= lvl;
        min_interval <= intv;
        now_ms       <= now;
        @(posedge clk);
        while (evt_stall)
            @(posedge clk);
        pending_results.push_back(throttle_predict(key, lvl, intv, now));
    endtask

    task automatic idle_sender(input int cycles);
        evt_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drained();
        evt_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // only while idle
    task automatic set_min_level(input logic [2:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        level_floor = v;
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic new_key_pool();
        pool_n = $urandom_range(2, 14);
        for (int i = 0; i < POOL_MAX; i++)
            key_pool[i] = KEY_IN_W'($urandom);
    endtask

    task automatic send_random_event();
        logic [KEY_IN_W-1:0] key;
        logic [LEVEL_W-1:0]  lvl;
        logic [TIME_W-1:0]   intv;
        logic [TIME_W-1:0]   now;
        if ($urandom_range(0, 99) < 82)
        begin
            // plausible traffic: recurring keys, advancing clock, short windows
            key = key_pool[$urandom_range(0, pool_n - 1)];
            if ($urandom_range(0, 19) == 0)
                clk_ms = clk_ms + $urandom_range(100, 5000);
            else
                clk_ms = clk_ms + $urandom_range(0, 40);
            now  = clk_ms;
            intv = $urandom_range(0, 64);
            lvl  = ($urandom_range(0, 9) == 0) ? LEVEL_W'($urandom_range(5, 7))
                                                : LEVEL_W'($urandom_range(0, 4));
        end
        else
        begin
            key = $urandom_range(0, 1) ? key_pool[$urandom_range(0, pool_n - 1)]
                                       : KEY_IN_W'($urandom);
            now = $urandom;
            case ($urandom_range(0, 2))
                0:       intv = '0;
                1:       intv = '1;
                default: intv = $urandom;
            endcase
            lvl = LEVEL_W'($urandom_range(0, 7));
        end
        send_event(key, lvl, intv, now);
    endtask

    task automatic test_table_fill();
        set_min_level(3'd0);
        send_event(16'h0000, 3'd0, 32'h0000_0000, 32'h0000_0000);
        send_event(16'hFFFF, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // elapsed time wraps past zero and stays inside the widest window
        send_event(16'hFFFF, 3'd4, 32'hFFFF_FFFF, 32'h0000_0005);
        send_event(16'h0000, 3'd1, 32'h0000_0000, 32'h0000_0000);
        send_event(16'h0000, 3'd2, 32'd10, 32'd9);
        send_event(16'h0000, 3'd3, 32'd10, 32'd10);
        for (int i = 1; i <= 6; i++)
            send_event(16'(i * 16'h1111), 3'd2, 32'd5, 32'd100);
        // table full: new keys overwrite slot 0
        send_event(16'h5A5A, 3'd4, 32'd0, 32'd200);
        send_event(16'h0000, 3'd4, 32'd0, 32'd300);
        send_event(16'h0000, 3'd4, 32'd50, 32'd320);
        wait_drained();
    endtask

    task automatic test_level_filter();
        set_min_level(3'd3);
        send_event(16'h1234, 3'd2, 32'd0, 32'd1000);
        send_event(16'h1234, 3'd3, 32'd0, 32'd1001);
        send_event(16'h1234, 3'd7, 32'd0, 32'd1002);
        wait_drained();
        set_min_level(3'd7);
        send_event(16'hABCD, 3'd6, 32'd0, 32'd2000);
        send_event(16'hABCD, 3'd7, 32'd0, 32'd2001);
        send_event(16'h0000, 3'd0, 32'd0, 32'd2002);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        logic [2:0] floors [8];
        int         burst_left;
        bit         no_idle;
        floors = '{3'd0, 3'd4, 3'd2, 3'd7, 3'd1, 3'd5, 3'd3, 3'd0};
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_drained();
            set_min_level(floors[ph]);
            no_idle   = (ph == 0);
            stall_pct = no_idle ? 0 : $urandom_range(10, 60);
            new_key_pool();
            clk_ms     = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF80 : $urandom;
            burst_left = $urandom_range(1, 24);
            for (int n = 0; n < 188; n++)
            begin
                send_random_event();
                if (n == 94 && $urandom_range(0, 1))
                    wait_drained();
                else if (!no_idle)
                begin
                    if (burst_left == 0)
                    begin
                        idle_sender($urandom_range(1, 12));
                        burst_left = $urandom_range(1, 24);
                    end
                    else
                        burst_left--;
                end
            end
        end
    endtask

    task automatic test_output_hold_off();
        wait_drained();
        set_min_level(3'd0);
        stall_pct = 20;
        new_key_pool();
        hold_off_len = 400;
        hold_off_req = 1'b1;
        for (int n = 0; n < 40; n++)
            send_random_event();
        wait_drained();
    endtask

    // receiver: runs of stall and no stall, plus an occasional long hold-off
    initial
    begin : stall_gen
        int   run_left;
        int   hold_left;
        logic stall_now;
        res_stall = 1'b0;
        run_left  = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_left    = hold_off_len;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
                run_left = 0;
            end
            else if (run_left == 0)
            begin
                stall_now = ($urandom_range(0, 99) < stall_pct);
                run_left  = stall_now ? $urandom_range(1, 7) : $urandom_range(1, 15);
                res_stall <= stall_now;
            end
            else
                run_left--;
        end
    end

    always @(posedge clk)
    begin : result_check
        throttle_res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: status %0d slot %0d evicted %0d",
                         $time, status, slot_index, evicted);
                fail_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, status);
                    fail_cnt++;
                end
                if (slot_index !== want.slot)
                begin
                    $display("%0t: slot_index mismatch: expected %0d, actual %0d",
                             $time, want.slot, slot_index);
                    fail_cnt++;
                end
                if (evicted !== want.evicted)
                begin
                    $display("%0t: evicted mismatch: expected %0d, actual %0d",
                             $time, want.evicted, evicted);
                    fail_cnt++;
                end
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        evt_valid    = 1'b0;
        key_id       = '0;
        level        = '0;
        min_interval = '0;
        now_ms       = '0;
        level_floor  = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_stamp[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_fill();
        test_level_filter();
        test_random_traffic();
        test_output_hold_off();
        if (fail_cnt == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/kett_pkg.sv
rtl/core/kett_mem.sv
rtl/core/kett_cmp.sv
rtl/core/keyed_event_throttle_table_unit.sv
rtl/core/kett_checker.sv
tb/tb_top.sv
